// File: rtl/core/sksa_pkg.sv
`timescale 1ns / 1ps
package sksa_pkg;
	localparam int SW = 24;
	localparam int VW = 48;
	localparam logic [VW-1:0] Q_RESET = 48'd17;
	localparam logic [VW-1:0] R_RESET = 48'd603979776;
	localparam logic [VW-1:0] P0_RESET = 48'd16777216000;
	localparam logic [SW-1:0] HIGH_RESET = 24'd1280000;
	localparam logic [15:0] MARGIN_MUL = 16'd6554;
	localparam logic [1:0] REG_Q = 2'd0;
	localparam logic [1:0] REG_R = 2'd1;
	localparam logic [1:0] REG_P0 = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRED, ST_DIV, ST_CORR, ST_VAR, ST_WRITE, ST_SCAN, ST_SCAN_LAST,
		ST_RANGE, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic seed;
		logic pred;
		logic div_init;
		logic div_step;
		logic corr;
		logic var_upd;
		logic ring_wr;
		logic scan_init;
		logic scan_step;
		logic range_upd;
	} cmd_t;

	typedef struct packed {
		logic valid_smp;
		logic seeded;
		logic div_done;
		logic scan_done;
	} sts_t;
endpackage

// File: rtl/core/sksa_ctrl.sv
`timescale 1ns / 1ps
module sksa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input sksa_pkg::sts_t sts,
	output sksa_pkg::cmd_t cmd
);
	sksa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sksa_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			sksa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = sksa_pkg::ST_PRED;
				end
			end
			sksa_pkg::ST_PRED: begin
				// invalid samples go straight to the result
				if (!sts.valid_smp) state_d = sksa_pkg::ST_OUT;
				else if (!sts.seeded) begin
					cmd.seed = 1'b1;
					state_d = sksa_pkg::ST_WRITE;
				end else begin
					cmd.pred = 1'b1;
					state_d = sksa_pkg::ST_DIV;
				end
			end
			sksa_pkg::ST_DIV: begin
				if (!sts.div_done) cmd.div_init = 1'b1;
				else cmd.div_step = 1'b1;
				state_d = sksa_pkg::ST_CORR;
			end
			sksa_pkg::ST_CORR: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.corr = 1'b1;
					state_d = sksa_pkg::ST_VAR;
				end
			end
			sksa_pkg::ST_VAR: begin
				cmd.var_upd = 1'b1;
				state_d = sksa_pkg::ST_WRITE;
			end
			sksa_pkg::ST_WRITE: begin
				cmd.ring_wr = 1'b1;
				cmd.scan_init = 1'b1;
				state_d = sksa_pkg::ST_SCAN;
			end
			sksa_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = sksa_pkg::ST_SCAN_LAST;
			end
			sksa_pkg::ST_SCAN_LAST: begin
				cmd.scan_step = 1'b1;
				state_d = sksa_pkg::ST_RANGE;
			end
			sksa_pkg::ST_RANGE: begin
				cmd.range_upd = 1'b1;
				state_d = sksa_pkg::ST_OUT;
			end
			sksa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = sksa_pkg::ST_IDLE;
			end
			default: state_d = sksa_pkg::ST_IDLE;
		endcase
	end
endmodule

// File: rtl/core/sksa_dp.sv
`timescale 1ns / 1ps
module sksa_dp #(
	parameter int WINDOW = 512
) (
	input logic clk,
	input logic arst_n,
	input sksa_pkg::cmd_t cmd,
	output sksa_pkg::sts_t sts,
	input logic [sksa_pkg::SW-1:0] sample,
	input logic [sksa_pkg::VW-1:0] process_noise,
	input logic [sksa_pkg::VW-1:0] measurement_noise,
	input logic [sksa_pkg::VW-1:0] initial_variance,
	output logic accepted,
	output logic [sksa_pkg::SW-1:0] smoothed,
	output logic [sksa_pkg::SW-1:0] range_low,
	output logic [sksa_pkg::SW-1:0] range_high
);
	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam int SW = sksa_pkg::SW;
	localparam int VW = sksa_pkg::VW;

	logic [SW-1:0] z_q, est_q, lo_b_q, hi_b_q;
	logic [VW-1:0] var_q, pp_q;
	logic seeded_q;
	logic [VW:0] den_q, rem_q;
	logic [SW-1:0] k_q;
	logic [4:0] dcnt_q;
	logic ddone_q;
	logic [AW-1:0] wpos_q, rd_q;
	logic [CW-1:0] fill_q, left_q;
	logic rv_q;
	logic [SW-1:0] raw_mem [WINDOW];
	logic [SW-1:0] flt_mem [WINDOW];
	logic [SW-1:0] raw_rd, flt_rd, mn_q, mx_q;
	logic [SW:0] vlo_q;

	// datapath helpers
	logic [VW:0] pp_sum;
	logic [VW+1:0] rem_sh, rem_dif;
	logic [SW:0] mag;
	logic [2*SW:0] prod;
	logic [SW:0] omk;
	logic [2*SW:0] vlo_prod, vhi_prod;
	logic [SW-1:0] span, mrg, m1, m2;
	logic [SW+15:0] mprod;
	logic [SW:0] hsum;

	assign pp_sum = {1'b0, var_q} + {1'b0, process_noise};
	assign rem_sh = {rem_q, 1'b0};
	assign rem_dif = rem_sh - {1'b0, den_q};
	assign mag = (z_q >= est_q) ? {1'b0, z_q - est_q} : {1'b0, est_q - z_q};
	assign prod = {1'b0, k_q} * {{SW{1'b0}}, mag};
	assign omk = 25'h1000000 - {1'b0, k_q};
	// (1-K)*Pp split into two 24-bit halves of Pp: the low half at correction, the high half at variance update
	assign vlo_prod = omk * {1'b0, pp_q[SW-1:0]};
	assign vhi_prod = omk * {1'b0, pp_q[VW-1:SW]};
	assign m1 = (raw_rd < flt_rd) ? raw_rd : flt_rd;
	assign m2 = (raw_rd < flt_rd) ? flt_rd : raw_rd;
	assign span = mx_q - mn_q;
	assign mprod = span * sksa_pkg::MARGIN_MUL;
	assign mrg = mprod[SW+15:16];
	assign hsum = {1'b0, mx_q} + {1'b0, mrg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			var_q <= initial_variance;
			seeded_q <= 1'b0;
			wpos_q <= '0;
			fill_q <= '0;
			lo_b_q <= '0;
			hi_b_q <= sksa_pkg::HIGH_RESET;
			ddone_q <= 1'b0;
			dcnt_q <= '0;
			left_q <= '0;
			rv_q <= 1'b0;
			k_q <= '0;
			rem_q <= '0;
		end else begin
			if (cmd.seed) begin
				est_q <= z_q;
				seeded_q <= 1'b1;
			end
			if (cmd.div_init) begin
				// zero denominator gives zero gain; pp >= den saturates
				if (den_q == '0) begin
					k_q <= '0;
					ddone_q <= 1'b1;
				end else if ({1'b0, pp_q} >= den_q) begin
					k_q <= '1;
					ddone_q <= 1'b1;
				end else begin
					rem_q <= {1'b0, pp_q};
					dcnt_q <= 5'd24;
					ddone_q <= 1'b0;
				end
			end
			if (cmd.div_step && !ddone_q) begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_dif[VW:0];
					k_q <= {k_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[VW:0];
					k_q <= {k_q[SW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd1) ddone_q <= 1'b1;
			end
			if (cmd.pred) ddone_q <= 1'b0;
			if (cmd.corr) begin
				if (z_q >= est_q) est_q <= est_q + prod[2*SW-1:SW] + SW'(prod[SW-1]);
				else est_q <= est_q - prod[2*SW-1:SW] - SW'(prod[SW-1]);
			end
			if (cmd.var_upd) var_q <= vhi_prod[VW-1:0] + {{(VW-SW-1){1'b0}}, vlo_q};
			if (cmd.ring_wr) begin
				wpos_q <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
				if (fill_q != CW'(WINDOW)) fill_q <= fill_q + 1'b1;
			end
			if (cmd.scan_init) begin
				left_q <= (fill_q != CW'(WINDOW)) ? fill_q + 1'b1 : fill_q;
				rv_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				rv_q <= (left_q != '0);
				if (left_q != '0) left_q <= left_q - 1'b1;
			end
			if (cmd.range_upd) begin
				lo_b_q <= (mn_q > mrg) ? mn_q - mrg : '0;
				hi_b_q <= hsum[SW] ? '1 : hsum[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) z_q <= sample;
		if (cmd.pred) begin
			pp_q <= pp_sum[VW] ? '1 : pp_sum[VW-1:0];
			den_q <= (pp_sum[VW] ? {1'b0, {VW{1'b1}}} : pp_sum) + {1'b0, measurement_noise};
		end
		if (cmd.corr) vlo_q <= vlo_prod[2*SW:SW];
		if (cmd.ring_wr) begin
			raw_mem[wpos_q] <= z_q;
			flt_mem[wpos_q] <= est_q;
		end
		if (cmd.scan_init) begin
			rd_q <= '0;
			mn_q <= '1;
			mx_q <= '0;
		end
		if (cmd.scan_step) begin
			raw_rd <= raw_mem[rd_q];
			flt_rd <= flt_mem[rd_q];
			rd_q <= (rd_q == AW'(WINDOW - 1)) ? '0 : rd_q + 1'b1;
			if (rv_q) begin
				if (m1 < mn_q) mn_q <= m1;
				if (m2 > mx_q) mx_q <= m2;
			end
		end
	end

	assign sts.valid_smp = (z_q != '0);
	assign sts.seeded = seeded_q;
	assign sts.div_done = ddone_q;
	assign sts.scan_done = (left_q == CW'(1));

	assign accepted = (z_q != '0);
	assign smoothed = est_q;
	assign range_low = lo_b_q;
	assign range_high = hi_b_q;
endmodule

// File: rtl/core/scalar_kalman_smoother_with_autorange.sv
`timescale 1ns / 1ps
// Scalar Kalman smoother with automatic display range.
// Input channel: sample with in_valid / in_stall; a request is taken when
// in_valid is high and in_stall low. Output channel: accepted, smoothed,
// range_low, range_high with out_valid / out_stall.
// One item is worked on at a time. A zero sample goes from acceptance
// straight to its result; the seeding sample goes through ring write,
// ring scan, range and result; a Kalman step first runs predict, the
// 24-step restoring divider, correction and variance update, and then
// ring write, ring scan (one entry of each ring per cycle through the
// ring read port), range and result.
// The result holds in the output register while out_stall is high; no new
// request is taken until the result leaves.
// Reset clears estimate, ring fill and low bound, sets the high bound to
// HIGH_RESET and loads the error variance with the P0 reset value.
// Configuration: APB writes at byte address 8*i, pready always high.
// Write registers only while the block is idle.
module scalar_kalman_smoother_with_autorange #(
	parameter int WINDOW = 512
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [23:0] sample,
	output logic out_valid,
	input logic out_stall,
	output logic accepted,
	output logic [23:0] smoothed,
	output logic [23:0] range_low,
	output logic [23:0] range_high,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	logic [47:0] q_q, r_q, p0_q;
	logic wr;
	logic [1:0] idx;
	sksa_pkg::cmd_t cmd;
	sksa_pkg::sts_t sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:3];

	// hold configuration registers; ignore out-of-range writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= sksa_pkg::Q_RESET;
			r_q <= sksa_pkg::R_RESET;
			p0_q <= sksa_pkg::P0_RESET;
		end else if (wr && paddr[2:0] == 3'd0) begin
			unique case (idx)
				sksa_pkg::REG_Q: q_q <= pwdata[47:0];
				sksa_pkg::REG_R: r_q <= pwdata[47:0];
				sksa_pkg::REG_P0: p0_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sksa_pkg::REG_Q: prdata = {16'd0, q_q};
			sksa_pkg::REG_R: prdata = {16'd0, r_q};
			sksa_pkg::REG_P0: prdata = {16'd0, p0_q};
			default: prdata = '0;
		endcase
	end

	sksa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	// datapath loads the error variance from p0 reset value at reset
	sksa_dp #(.WINDOW(WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .sample(sample),
		.process_noise(q_q), .measurement_noise(r_q),
		.initial_variance(sksa_pkg::P0_RESET),
		.accepted(accepted), .smoothed(smoothed),
		.range_low(range_low), .range_high(range_high)
	);
endmodule

// File: rtl/core/sksa_checker.sv
`timescale 1ns / 1ps
module sksa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic accepted,
	input logic [23:0] range_low,
	input logic [23:0] range_high
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken while result pending");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> range_low <= range_high) else $error("range inverted");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind scalar_kalman_smoother_with_autorange sksa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
	.range_low(range_low), .range_high(range_high)
);

// File: test/scalar_kalman_smoother_with_autorange_tb.sv
`timescale 1ns / 1ps
module scalar_kalman_smoother_with_autorange_tb;
	localparam int WIN = 512;
	localparam int LIMIT = 3_000_000;
	localparam logic [sksa_pkg::VW-1:0] VMAX = {sksa_pkg::VW{1'b1}};
	localparam logic [sksa_pkg::SW-1:0] SMAX = {sksa_pkg::SW{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [23:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted;
	logic [23:0] smoothed, range_low, range_high;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	int mismatches = 0;
	int cycles = 0;
	int requests_sent = 0;
	int results_seen = 0;
	bit quiet = 1'b0;	// no idling on either side while set

	scalar_kalman_smoother_with_autorange #(.WINDOW(WIN)) u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// print one line per mismatch and count it
	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
	endtask

	typedef struct packed {
		logic acc;
		logic [sksa_pkg::SW-1:0] est;
		logic [sksa_pkg::SW-1:0] lo;
		logic [sksa_pkg::SW-1:0] hi;
	} smooth_out_t;

	// filter state and pending outputs; one output per accepted request
	class kalman_scoreboard;
		logic [sksa_pkg::VW-1:0] q_noise, r_noise;
		logic [63:0] est, pvar;
		bit seeded;
		logic [sksa_pkg::SW-1:0] raw_ring[WIN];
		logic [sksa_pkg::SW-1:0] est_ring[WIN];
		int wpos, fill;
		logic [63:0] low_b, high_b;
		smooth_out_t pending[$];

		function new();
			q_noise = sksa_pkg::Q_RESET;
			r_noise = sksa_pkg::R_RESET;
			est = 0;
			pvar = sksa_pkg::P0_RESET;	// loaded only through reset
			seeded = 0;
			wpos = 0;
			fill = 0;
			low_b = 0;
			high_b = sksa_pkg::HIGH_RESET;
		endfunction

		function logic [63:0] gain(input logic [63:0] num, input logic [63:0] den);
			logic [63:0] rem, q;
			rem = num;
			q = 0;
			if (den == 0) return 0;
			if (num >= den) return SMAX;
			for (int i = 0; i < 24; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= den) begin
					rem = rem - den;
					q[0] = 1'b1;
				end
			end
			return q & 64'hFFFFFF;
		endfunction

		function void kalman_update(input logic [63:0] z);
			logic [63:0] pp, k, mag, corr;
			pp = pvar + q_noise;
			if (pp > VMAX) pp = VMAX;
			k = gain(pp, pp + r_noise);
			mag = (z >= est) ? z - est : est - z;
			corr = (k * mag + 64'h800000) >> 24;
			est = ((z >= est) ? est + corr : est - corr) & 64'hFFFFFF;
			// floor((1-K)*Pp) split so the product stays inside 64 bits
			pvar = ((64'h1000000 - k) * (pp >> 24) + (((64'h1000000 - k) * (pp & 64'hFFFFFF)) >> 24))
				& 64'hFFFF_FFFF_FFFF;
		endfunction

		function void autorange();
			logic [63:0] lo, hi, margin;
			lo = SMAX;
			hi = 0;
			for (int i = 0; i < fill; i++) begin
				if (raw_ring[i] < lo) lo = raw_ring[i];
				if (raw_ring[i] > hi) hi = raw_ring[i];
				if (est_ring[i] < lo) lo = est_ring[i];
				if (est_ring[i] > hi) hi = est_ring[i];
			end
			margin = ((hi - lo) * sksa_pkg::MARGIN_MUL) >> 16;
			low_b = (lo > margin) ? lo - margin : 0;
			high_b = (hi + margin > SMAX) ? SMAX : hi + margin;
		endfunction

		function void note_sample(input logic [sksa_pkg::SW-1:0] z);
			smooth_out_t o;
			if (z != 0) begin
				if (!seeded) begin
					est = z;
					seeded = 1;
				end else begin
					kalman_update(z);
				end
				raw_ring[wpos] = z;
				est_ring[wpos] = est[sksa_pkg::SW-1:0];
				wpos = (wpos + 1) % WIN;
				if (fill < WIN) fill++;
				autorange();
			end
			o.acc = (z != 0);
			o.est = est[sksa_pkg::SW-1:0];
			o.lo = low_b[sksa_pkg::SW-1:0];
			o.hi = high_b[sksa_pkg::SW-1:0];
			pending = {pending, o};
		endfunction

		task check_result(input logic a, input logic [sksa_pkg::SW-1:0] s,
				input logic [sksa_pkg::SW-1:0] l, input logic [sksa_pkg::SW-1:0] h);
			smooth_out_t o;
			if (pending.size() == 0) begin
				report("unexpected result", s, 0);
				return;
			end
			o = pending.pop_front();
			if (a !== o.acc) report("accepted", a, o.acc);
			if (s !== o.est) report("smoothed", s, o.est);
			if (l !== o.lo) report("range_low", l, o.lo);
			if (h !== o.hi) report("range_high", h, o.hi);
		endtask
	endclass

	kalman_scoreboard sb = new();

	// observe both handshakes with the values held before the edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && !in_stall) sb.note_sample(sample);
		if (out_valid && !out_stall) begin
			sb.check_result(accepted, smoothed, range_low, range_high);
			results_seen++;
		end
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// result side: stall for a random number of cycles, then take one result
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 14);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// hand one request to the block; keep valid high across back-to-back requests
	task automatic send_sample(input logic [sksa_pkg::SW-1:0] z);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= z;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic drain();
		@(posedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// APB write: setup, then access; register updates at the access edge
	task automatic write_reg(input logic [1:0] idx, input logic [sksa_pkg::VW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 3;
		pwdata <= 64'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == sksa_pkg::REG_Q) sb.q_noise = val;
		else if (idx == sksa_pkg::REG_R) sb.r_noise = val;
		// initial variance only matters through reset, which never comes again
	endtask

	function automatic logic [sksa_pkg::SW-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 12) return SMAX;
		if (r < 15) return 24'd1;
		if (r < 50) return 24'($urandom) >> $urandom_range(0, 23);
		if (r < 80) return 24'($urandom_range(1000, 40000));	// realistic rates
		return 24'($urandom);
	endfunction

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
			send_sample(rand_sample());
		end
		quiet = 1'b0;
		drain();
	endtask

	initial begin
		logic [sksa_pkg::SW-1:0] directed[$];
		directed = '{24'h0, 24'h1, 24'hFFFFFF, 24'h0, 24'h000100, 24'hFFFFFF,
			24'hAAAAAA, 24'h555555, 24'h800000, 24'h7FFFFF, 24'h0, 24'h1,
			24'h002710, 24'h002800, 24'h0026F0, 24'hFFFFFE, 24'h000002, 24'h0,
			24'h123456, 24'hFEDCBA};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// invalid before seeding, seeding, extremes and bit patterns at reset settings
		foreach (directed[i]) send_sample(directed[i]);
		drain();

		// no noise at all: gain saturates, then variance collapses to zero
		// and the zero-denominator path holds the estimate
		write_reg(sksa_pkg::REG_Q, '0);
		write_reg(sksa_pkg::REG_R, '0);
		random_run(40);

		// largest noise: predicted variance saturates
		write_reg(sksa_pkg::REG_Q, VMAX);
		write_reg(sksa_pkg::REG_R, VMAX);
		write_reg(sksa_pkg::REG_P0, VMAX);
		random_run(60);

		// gain of one from a saturated variance
		write_reg(sksa_pkg::REG_R, '0);
		random_run(30);

		// assorted settings; enough accepted samples to wrap the rings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(sksa_pkg::REG_Q, (ph % 2) ? VMAX >> $urandom_range(0, 47)
				: 48'($urandom_range(0, 4096)));
			write_reg(sksa_pkg::REG_R, (ph % 3 == 0) ? 48'({$urandom, $urandom})
				: sksa_pkg::R_RESET >> $urandom_range(0, 10));
			write_reg(sksa_pkg::REG_P0, 48'({$urandom, $urandom}));
			random_run(92);
		end

		$display("Sent %0d requests and checked %0d results over %0d cycles,",
			requests_sent, results_seen, cycles);
		$display("covering zero, saturated and random noise settings with ring wraparound.");
		if (mismatches == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, sb.pending.size());
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/core/sksa_pkg.sv
rtl/core/sksa_ctrl.sv
rtl/core/sksa_dp.sv
rtl/core/scalar_kalman_smoother_with_autorange.sv
rtl/core/sksa_checker.sv
test/scalar_kalman_smoother_with_autorange_tb.sv
